@@ hdl/awu_pkg.sv @@
package awu_pkg;

  // Fixed field widths of the result and input beats.
  localparam int WEIGHT_W = 16;
  localparam int BETA_W   = 17;
  localparam int POS_W    = 6;

  // Q1.16 one, saturated beta and saturated Q0.16 weight.
  localparam logic [BETA_W-1:0]   ONE_Q16    = 17'h10000;
  localparam logic [BETA_W-1:0]   BETA_MAX   = 17'h1FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;

  // One input beat.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                correct;
    logic                last;
  } awu_in_t;

  // One result beat.
  typedef struct packed {
    logic [WEIGHT_W-1:0] new_weight;
    logic [BETA_W-1:0]   beta;
    logic                stop;
    logic [POS_W-1:0]    position;
    logic                final_res;
  } awu_out_t;

endpackage

@@ hdl/awu_mul.sv @@
module awu_mul
  import awu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [WEIGHT_W-1:0]       mcand,
  input  logic [BETA_W-1:0]         mplier,
  output logic                      done,
  output logic [WEIGHT_W+BETA_W-1:0] product
);

  localparam int PW    = WEIGHT_W + BETA_W;
  localparam int CNT_W = $clog2(WEIGHT_W + 1);

  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [WEIGHT_W-1:0] a_r;
  logic [PW-1:0]       b_r;
  logic [PW-1:0]       acc_r;

  // Control: step counter and the done pulse after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(WEIGHT_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one multiplicand bit per cycle, shift and add.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mcand;
      b_r   <= PW'(mplier);
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      a_r <= a_r >> 1;
      b_r <= b_r << 1;
      if (a_r[0]) begin
        acc_r <= acc_r + b_r;
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ hdl/awu_div.sv @@
module awu_div
  import awu_pkg::*;
#(
  parameter int DW = 38
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW:0]       dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [BETA_W-1:0] quotient
);

  // The caller guarantees dividend < 2 * divisor, so the quotient of
  // dividend * 2^16 / divisor fits BETA_W bits.
  localparam int CNT_W = $clog2(BETA_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DW:0]       rem_r;
  logic [DW-1:0]     div_r;
  logic [BETA_W-1:0] quo_r;
  logic              ge;
  logic [DW:0]       diff;
  logic [DW:0]       part;

  // One restoring step: compare, subtract, shift in the next zero bit.
  assign ge   = (rem_r >= {1'b0, div_r});
  assign diff = rem_r - {1'b0, div_r};
  assign part = ge ? diff : rem_r;

  // Control: step counter and the done pulse after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(BETA_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= {part[DW-1:0], 1'b0};
      quo_r <= {quo_r[BETA_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/adaboost_weight_update_unit.sv @@
// AdaBoost.M1 weight update, one reweighting round at a time.
// Input beats (weight, correct, last) are taken when start is high and busy
// is low, one per cycle during the load. A beat with last set closes the
// load and raises busy; beats beyond MAX_EXAMPLES are dropped, but a dropped
// last beat still closes the load.
// After the load the block forms beta with the restoring divider, or
// saturates it when the correct sum is zero or the error sum reaches twice
// it. When stop is set it emits the stored weights as they are, one result
// per example. Otherwise it makes a sum pass (a shift-add serial multiply
// per example) and an output pass (the same multiply plus a serial divide
// per example, or a zero weight when the sum is zero); one shift-add
// multiplier and one restoring divider are shared by all these steps.
// Each result is shown for one cycle with out_valid high; the receiver
// cannot stall. busy falls in the cycle the final result is shown, so the
// next round may start loading then.
// Reset clears the round counters and sums; the weight store needs no
// clearing because only entries written in the current round are read.
module adaboost_weight_update_unit
  import awu_pkg::*;
#(
  parameter int MAX_EXAMPLES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  awu_in_t  in_data,
  output logic     out_valid,
  output awu_out_t out_data
);

  localparam int AW     = $clog2(MAX_EXAMPLES);
  localparam int CW     = $clog2(MAX_EXAMPLES + 1);
  localparam int SUM_W  = WEIGHT_W + $clog2(MAX_EXAMPLES);
  localparam int TERM_W = 2 * WEIGHT_W;
  localparam int NORM_W = TERM_W + $clog2(MAX_EXAMPLES);
  localparam int PROD_W = WEIGHT_W + BETA_W;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BETA,
    S_BETA_WAIT,
    S_DECIDE,
    S_READ,
    S_FETCH,
    S_MUL,
    S_DIV
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [SUM_W-1:0]  cs_r, cs_nxt;
  logic [SUM_W-1:0]  err_r, err_nxt;
  logic [BETA_W-1:0] beta_r, beta_nxt;
  logic              stop_r, stop_nxt;
  logic [NORM_W-1:0] norm_r, norm_nxt;
  logic              out_phase_r, out_phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  awu_out_t          out_r, out_nxt;

  logic                   accept;
  logic                   store_ok;
  logic [WEIGHT_W:0]      mem [MAX_EXAMPLES];
  logic [WEIGHT_W:0]      rd_q_r;
  logic                   is_last_k;
  logic                   mul_start;
  logic                   mul_done;
  logic [BETA_W-1:0]      mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [TERM_W-1:0]      term;
  logic                   div_start;
  logic                   div_done;
  logic [NORM_W:0]        div_dividend;
  logic [NORM_W-1:0]      div_divisor;
  logic [BETA_W-1:0]      div_q;

  assign accept   = start && (state_r == S_LOAD);
  assign store_ok = (cnt_r < CW'(MAX_EXAMPLES));

  // Weight store: written during the load, read at the current example.
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[cnt_r[AW-1:0]] <= {in_data.correct, in_data.weight};
    end
    rd_q_r <= mem[k_r];
  end

  assign is_last_k = ((CW'(k_r) + CW'(1)) == cnt_r);
  assign term      = mul_p[TERM_W-1:0];

  // Correct examples scale by beta, wrong ones by one.
  assign mul_b = rd_q_r[WEIGHT_W] ? beta_r : ONE_Q16;

  // The divider serves beta first, then the normalized weights of the output pass.
  assign div_dividend = (state_r == S_BETA) ? (NORM_W+1)'(err_r) : (NORM_W+1)'(term);
  assign div_divisor  = (state_r == S_BETA) ? NORM_W'(cs_r) : norm_r;

  awu_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (rd_q_r[WEIGHT_W-1:0]),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  awu_div #(
    .DW (NORM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Round sequencer: load, beta, sum pass, output pass (no sum pass when stop is set).
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    cs_nxt        = cs_r;
    err_nxt       = err_r;
    beta_nxt      = beta_r;
    stop_nxt      = stop_r;
    norm_nxt      = norm_r;
    out_phase_nxt = out_phase_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    out_nxt.beta      = beta_r;
    out_nxt.stop      = stop_r;
    out_nxt.position  = POS_W'(k_r);
    out_nxt.final_res = is_last_k;

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + CW'(1);
            if (in_data.correct) begin
              cs_nxt = cs_r + SUM_W'(in_data.weight);
            end else begin
              err_nxt = err_r + SUM_W'(in_data.weight);
            end
          end
          if (in_data.last) begin
            state_nxt = S_BETA;
          end
        end
      end

      S_BETA: begin
        // A zero correct sum or a quotient past the Q1.16 range saturates.
        if ((cs_r == '0) || ({1'b0, err_r} >= {cs_r, 1'b0})) begin
          beta_nxt  = BETA_MAX;
          state_nxt = S_DECIDE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_BETA_WAIT;
        end
      end

      S_BETA_WAIT: begin
        if (div_done) begin
          beta_nxt  = div_q;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        stop_nxt      = (cs_r == '0) || (err_r > cs_r);
        out_phase_nxt = (cs_r == '0) || (err_r > cs_r);
        k_nxt         = '0;
        norm_nxt      = '0;
        state_nxt     = S_READ;
      end

      S_READ: begin
        state_nxt = S_FETCH;
      end

      S_FETCH: begin
        if (stop_r) begin
          out_valid_nxt      = 1'b1;
          out_nxt.new_weight = rd_q_r[WEIGHT_W-1:0];
        end else if (out_phase_r && (norm_r == '0)) begin
          out_valid_nxt      = 1'b1;
          out_nxt.new_weight = '0;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        if (mul_done) begin
          if (out_phase_r) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            norm_nxt = norm_r + NORM_W'(term);
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          out_valid_nxt      = 1'b1;
          out_nxt.new_weight = div_q[BETA_W-1] ? WEIGHT_MAX : div_q[WEIGHT_W-1:0];
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Step to the next example once this one is finished.
    if (((state_r == S_FETCH) && (stop_r || (out_phase_r && (norm_r == '0)))) ||
        ((state_r == S_MUL) && mul_done && !out_phase_r) ||
        ((state_r == S_DIV) && div_done)) begin
      if (is_last_k) begin
        if (out_phase_r) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
          cs_nxt    = '0;
          err_nxt   = '0;
        end else begin
          out_phase_nxt = 1'b1;
          k_nxt         = '0;
          state_nxt     = S_READ;
        end
      end else begin
        k_nxt     = k_r + AW'(1);
        state_nxt = S_READ;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      cs_r        <= '0;
      err_r       <= '0;
      stop_r      <= 1'b0;
      out_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      cs_r        <= cs_nxt;
      err_r       <= err_nxt;
      stop_r      <= stop_nxt;
      out_phase_r <= out_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    beta_r <= beta_nxt;
    norm_r <= norm_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
